/* src/vdhr_pkg.sv */
// Package for the vertex dedup hash remap block.
// Payload structs, controller states, command/status structs and hash constants.
// No dependencies.
package vdhr_pkg;

   localparam int unsigned NUM_KEY_FIELDS = 8;
   localparam int unsigned INDEX_W        = 12;
   localparam int unsigned UNIQUE_W       = 13;

   localparam logic [31:0] HASH_SEED  = 32'h811c9dc5;
   localparam logic [31:0] HASH_MUL   = 32'h9e3779b1;
   localparam logic [31:0] FIN_MUL_1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_MUL_2  = 32'hc2b2ae35;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_START  = 1'b1;

   localparam logic [1:0] CSR_KEY_WORDS  = 2'd0;
   localparam logic [1:0] CSR_KEY_BYTES  = 2'd1;
   localparam logic [1:0] CSR_TABLE_BITS = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [31:0] key_word_0;
      logic [31:0] key_word_1;
      logic [31:0] key_word_2;
      logic [31:0] key_word_3;
      logic [31:0] key_word_4;
      logic [31:0] key_word_5;
      logic [31:0] key_word_6;
      logic [31:0] key_word_7;
   } req_type;

   typedef struct packed {
      logic [11:0] unique_index;
      logic [31:0] vertex_number;
      logic        is_new;
      logic        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic load_key;
      logic start_mesh;
      logic clr_step;
      logic hash_step;
      logic fin1;
      logic fin2;
      logic fin3;
      logic probe_next;
      logic commit_new;
      logic commit_hit;
      logic commit_full;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_last;
      logic slot_empty;
      logic key_hit;
      logic probe_last;
      logic out_free;
   } stat_type;

endpackage

/* src/vdhr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vdhr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/vdhr_ctrl.sv */
// Controller for the vertex dedup block: clear sweep, hash sequencing, probe loop.
// Depends on vdhr_pkg.
module vdhr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_opcode,
   output logic              req_ready,
   input  vdhr_pkg::stat_type stat,
   output vdhr_pkg::cmd_type  cmd
);

   vdhr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdhr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vdhr_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = vdhr_pkg::ST_IDLE;
         end
         vdhr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == vdhr_pkg::OP_START) ? vdhr_pkg::ST_CLEAR
                                                              : vdhr_pkg::ST_HASH;
            end
         end
         vdhr_pkg::ST_HASH: begin
            if (stat.hash_last) state_in = vdhr_pkg::ST_FIN1;
         end
         vdhr_pkg::ST_FIN1: state_in = vdhr_pkg::ST_FIN2;
         vdhr_pkg::ST_FIN2: state_in = vdhr_pkg::ST_FIN3;
         vdhr_pkg::ST_FIN3: state_in = vdhr_pkg::ST_READ;
         vdhr_pkg::ST_READ: state_in = vdhr_pkg::ST_CHECK;
         vdhr_pkg::ST_CHECK: begin
            if (stat.slot_empty || stat.key_hit || stat.probe_last) begin
               if (stat.out_free) state_in = vdhr_pkg::ST_IDLE;
            end else begin
               state_in = vdhr_pkg::ST_READ;
            end
         end
         default: state_in = vdhr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         vdhr_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         vdhr_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_key   = req_valid && (req_opcode == vdhr_pkg::OP_INSERT);
            cmd.start_mesh = req_valid && (req_opcode == vdhr_pkg::OP_START);
         end
         vdhr_pkg::ST_HASH: cmd.hash_step = 1'b1;
         vdhr_pkg::ST_FIN1: cmd.fin1 = 1'b1;
         vdhr_pkg::ST_FIN2: cmd.fin2 = 1'b1;
         vdhr_pkg::ST_FIN3: cmd.fin3 = 1'b1;
         vdhr_pkg::ST_READ: ;
         vdhr_pkg::ST_CHECK: begin
            // empty slot wins over a compare against stale key data
            if (stat.slot_empty) begin
               cmd.commit_new = stat.out_free;
            end else if (stat.key_hit) begin
               cmd.commit_hit = stat.out_free;
            end else if (stat.probe_last) begin
               cmd.commit_full = stat.out_free;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

/* src/vdhr_dpath.sv */
// Datapath: config registers, key latch, hash unit, slot RAMs, counters, result register.
// Depends on vdhr_pkg and vdhr_ram.
module vdhr_dpath #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned KEY_WORDS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  vdhr_pkg::req_type  req_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output vdhr_pkg::rsp_type  rsp_data,
   input  vdhr_pkg::cmd_type  cmd,
   output vdhr_pkg::stat_type stat
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned WI_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int unsigned KEY_W  = 32 * KEY_WORDS;
   localparam int unsigned META_W = 1 + vdhr_pkg::INDEX_W;

   logic [3:0] key_words_ff;
   logic [5:0] key_bytes_ff;
   logic [3:0] table_bits_ff;

   logic [31:0]        key_ff [KEY_WORDS];
   logic [WI_W-1:0]    nm1_ff, wcnt_ff;
   logic [ADDR_W-1:0]  mask_ff, bucket_ff, probe_ff, clr_ff;
   logic [31:0]        hash_ff, hash_in;
   logic [31:0]        vertex_ff, number_ff;
   logic [vdhr_pkg::UNIQUE_W-1:0] unique_ff;
   logic               rsp_valid_ff;
   vdhr_pkg::rsp_type  rsp_ff;

   logic [31:0]       words_in [vdhr_pkg::NUM_KEY_FIELDS];
   logic [WI_W-1:0]   nm1_in;
   logic [ADDR_W-1:0] mask_in;
   logic [31:0]       fin_t;

   logic               meta_we;
   logic [ADDR_W-1:0]  meta_wa;
   logic [META_W-1:0]  meta_wd, meta_rd;
   logic [KEY_W-1:0]   key_wd, key_rd;
   logic               hit;

   assign words_in[0] = req_data.key_word_0;
   assign words_in[1] = req_data.key_word_1;
   assign words_in[2] = req_data.key_word_2;
   assign words_in[3] = req_data.key_word_3;
   assign words_in[4] = req_data.key_word_4;
   assign words_in[5] = req_data.key_word_5;
   assign words_in[6] = req_data.key_word_6;
   assign words_in[7] = req_data.key_word_7;

   // word count and table mask with out-of-range values clamped
   always_comb begin
      int n;
      int tb;
      n = int'(key_words_ff);
      if (n < 1) n = 1;
      if (n > int'(KEY_WORDS)) n = int'(KEY_WORDS);
      nm1_in = WI_W'(n - 1);
      tb = int'(table_bits_ff);
      if (tb < 1) tb = 1;
      if (tb > int'(ADDR_W)) tb = int'(ADDR_W);
      for (int i = 0; i < int'(ADDR_W); i++) begin
         mask_in[i] = (i < tb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_words_ff  <= 4'd1;
         key_bytes_ff  <= 6'd4;
         table_bits_ff <= 4'd12;
      end else if (csr_valid) begin
         case (csr_index)
            vdhr_pkg::CSR_KEY_WORDS:  key_words_ff  <= csr_data[3:0];
            vdhr_pkg::CSR_KEY_BYTES:  key_bytes_ff  <= csr_data[5:0];
            vdhr_pkg::CSR_TABLE_BITS: table_bits_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // hash unit: one multiply per cycle
   always_comb begin
      hash_in = hash_ff;
      fin_t   = '0;
      if (cmd.load_key) begin
         hash_in = vdhr_pkg::HASH_SEED;
      end else if (cmd.hash_step) begin
         hash_in = (hash_ff ^ key_ff[wcnt_ff]) * vdhr_pkg::HASH_MUL;
      end else if (cmd.fin1) begin
         fin_t   = hash_ff ^ {26'd0, key_bytes_ff};
         fin_t   = fin_t ^ (fin_t >> 16);
         hash_in = fin_t * vdhr_pkg::FIN_MUL_1;
      end else if (cmd.fin2) begin
         fin_t   = hash_ff ^ (hash_ff >> 13);
         hash_in = fin_t * vdhr_pkg::FIN_MUL_2;
      end else if (cmd.fin3) begin
         hash_in = hash_ff ^ (hash_ff >> 16);
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      if (cmd.load_key) begin
         for (int i = 0; i < int'(KEY_WORDS); i++) begin
            key_ff[i] <= words_in[i];
         end
         nm1_ff    <= nm1_in;
         mask_ff   <= mask_in;
         number_ff <= vertex_ff;
         wcnt_ff   <= '0;
      end else if (cmd.hash_step) begin
         wcnt_ff <= wcnt_ff + 1'b1;
      end
      if (cmd.fin3) begin
         bucket_ff <= hash_in[ADDR_W-1:0] & mask_ff;
         probe_ff  <= '0;
      end else if (cmd.probe_next) begin
         bucket_ff <= (bucket_ff + probe_ff + 1'b1) & mask_ff;
         probe_ff  <= probe_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff <= '0;
         unique_ff <= '0;
         clr_ff    <= '0;
      end else begin
         if (cmd.start_mesh) begin
            vertex_ff <= '0;
            unique_ff <= '0;
            clr_ff    <= '0;
         end else begin
            if (cmd.load_key) vertex_ff <= vertex_ff + 1'b1;
            if (cmd.commit_new) unique_ff <= unique_ff + 1'b1;
            if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   assign meta_we = cmd.clr_step || cmd.commit_new;
   assign meta_wa = cmd.clr_step ? clr_ff : bucket_ff;
   assign meta_wd = cmd.clr_step ? '0 : {1'b1, unique_ff[vdhr_pkg::INDEX_W-1:0]};

   always_comb begin
      for (int i = 0; i < int'(KEY_WORDS); i++) begin
         key_wd[32*i +: 32] = key_ff[i];
      end
   end

   vdhr_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_addr (bucket_ff),
      .rd_data (meta_rd)
   );

   vdhr_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit_new),
      .wr_addr (bucket_ff),
      .wr_data (key_wd),
      .rd_addr (bucket_ff),
      .rd_data (key_rd)
   );

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < int'(KEY_WORDS); i++) begin
         if ((WI_W'(i) <= nm1_ff) && (key_rd[32*i +: 32] != key_ff[i])) hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit_new || cmd.commit_hit || cmd.commit_full) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_new || cmd.commit_hit || cmd.commit_full) begin
         rsp_ff.vertex_number <= number_ff;
         rsp_ff.is_new        <= cmd.commit_new;
         rsp_ff.status        <= cmd.commit_full;
         if (cmd.commit_new) begin
            rsp_ff.unique_index <= unique_ff[vdhr_pkg::INDEX_W-1:0];
         end else if (cmd.commit_hit) begin
            rsp_ff.unique_index <= meta_rd[vdhr_pkg::INDEX_W-1:0];
         end else begin
            rsp_ff.unique_index <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.clr_last   = &clr_ff;
   assign stat.hash_last  = (wcnt_ff == nm1_ff);
   assign stat.slot_empty = !meta_rd[META_W-1];
   assign stat.key_hit    = hit;
   assign stat.probe_last = (probe_ff == mask_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

/* src/vertex_dedup_hash_remap.sv */
// Top level of the vertex dedup hash remap block: controller plus datapath.
// Depends on vdhr_pkg, vdhr_ctrl, vdhr_dpath (and vdhr_ram below it).
//
//   port group | direction | carries
//   req_*      | in        | opcode and eight key words per item
//   rsp_*      | out       | unique index, vertex number, new flag, status
//   csr_*      | in        | register index and write data
//
// An insert is accepted in idle, hashes its key_words key words in turn, then
// runs the finalizer states FIN1 to FIN3, then a slot RAM read and a compare per probe.
// Reset and every start item sweep the slot table, one slot a cycle; no item
// is taken meanwhile. A stalled result holds in the output register; the next
// item hashes behind it and waits only at commit.
module vertex_dedup_hash_remap #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned KEY_WORDS   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vdhr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vdhr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   vdhr_pkg::cmd_type  cmd;
   vdhr_pkg::stat_type stat;
   logic               req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   vdhr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vdhr_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WORDS(KEY_WORDS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

`ifndef SYNTH
   a_commit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit_new, cmd.commit_hit, cmd.commit_full}))
      else $error("more than one commit in a cycle");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_new || cmd.commit_hit || cmd.commit_full) |-> (!rsp_valid || rsp_ready))
      else $error("result committed over a pending one");

   a_start_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode) |=> !req_ready)
      else $error("item taken right after start");

   a_no_clear_write_in_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !(cmd.commit_new || cmd.probe_next || cmd.load_key))
      else $error("clear sweep overlaps item work");
`endif

endmodule
